>>> rtl/hsd_pkg.sv
// Shared types and constants for the serialized-tree Huffman decoder.
`default_nettype none

package hsd_pkg;

  localparam int unsigned LenW   = 24;
  localparam int unsigned NodeW  = 9;
  localparam int unsigned SymW   = 8;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned LeafCntW = 4;

  localparam logic [LeafCntW-1:0] LeafBits = 4'd8;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    PH_BUILD  = 2'd0,
    PH_DECODE = 2'd1,
    PH_STOP   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SLOT_ROOT  = 2'd0,
    SLOT_LEFT  = 2'd1,
    SLOT_RIGHT = 2'd2
  } slot_e;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_OVERFLOW = 1'b1
  } status_e;

  // Write request into the child tables
  typedef struct packed {
    logic             we_left;
    logic             we_right;
    logic [IdxW-1:0]  addr;
    logic [NodeW-1:0] data;
  } child_wr_t;

endpackage

`default_nettype wire

>>> rtl/hsd_in_if.sv
// Input channel: one compressed byte per request.
`default_nettype none

interface hsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

`default_nettype wire

>>> rtl/hsd_out_if.sv
// Output channel: one decoded result per request.
`default_nettype none

interface hsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  symbol;
  logic [23:0] repeat_res;
  logic        status;
  logic        last;

  modport source (output valid, output symbol, output repeat_res, output status,
                  output last, input ready);
  modport sink   (input valid, input symbol, input repeat_res, input status,
                  input last, output ready);
endinterface

`default_nettype wire

>>> rtl/hsd_child_mem.sv
// Left and right child tables of the internal nodes, registered read.
`default_nettype none

module hsd_child_mem (
  input  wire logic                      clk_i,
  input  wire hsd_pkg::child_wr_t        wr_i,
  input  wire logic                      rd_en_i,
  input  wire logic [hsd_pkg::IdxW-1:0]  rd_addr_i,
  output logic      [hsd_pkg::NodeW-1:0] left_o,
  output logic      [hsd_pkg::NodeW-1:0] right_o
);

  localparam int unsigned Depth = 1 << hsd_pkg::IdxW;

  logic [hsd_pkg::NodeW-1:0] left_mem  [Depth];
  logic [hsd_pkg::NodeW-1:0] right_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i.we_left) begin
      left_mem[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.we_right) begin
      right_mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      left_o  <= left_mem[rd_addr_i];
      right_o <= right_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/huffman_serialized_tree_decoder.sv
// Huffman decoder with pre-order serialized tree: top level.
// Each stream bit is handled by S_FETCH (table/stack read), then S_EXEC (execute); a new
// byte is taken only after the last bit of the current byte executes or the stream stops.
// A result leaves the output register the cycle after its bit executes; a bit that
// emits waits while the output register is still held by the sink.
// Reset (async, active low) clears control, counters and output_length; tables are not cleared.
`default_nettype none

module huffman_serialized_tree_decoder #(
  parameter int unsigned MAX_NODE_INDEX = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [hsd_pkg::LenW-1:0]   cfg_wdata_i,
  hsd_in_if.sink                          in_i,
  hsd_out_if.source                       out_o
);

  localparam int unsigned NodeW = hsd_pkg::NodeW;
  localparam int unsigned IdxW  = hsd_pkg::IdxW;
  localparam int unsigned SymW  = hsd_pkg::SymW;
  localparam int unsigned LenW  = hsd_pkg::LenW;
  localparam int unsigned Depth = 1 << IdxW;
  localparam logic [NodeW:0] MaxNode = (NodeW+1)'(MAX_NODE_INDEX);
  localparam logic [NodeW:0] IntBase = (NodeW+1)'(Depth);

  hsd_pkg::state_e state_q, state_d;
  hsd_pkg::phase_e phase_q, phase_d;
  hsd_pkg::slot_e  slot_q, slot_d;

  logic [SymW-1:0]             shift_q, shift_d;
  logic [2:0]                  bit_cnt_q, bit_cnt_d;
  logic [NodeW-1:0]            sp_q, sp_d;
  logic [NodeW-1:0]            next_node_q, next_node_d;
  logic [NodeW-1:0]            root_q, root_d;
  logic [NodeW-1:0]            walk_q, walk_d;
  logic [hsd_pkg::LeafCntW-1:0] leaf_cnt_q, leaf_cnt_d;
  logic [SymW-1:0]             leaf_val_q, leaf_val_d;
  logic [LenW-1:0]             produced_q, produced_d;
  logic [IdxW-1:0]             slot_idx_q, slot_idx_d;
  logic [LenW-1:0]             len_q;

  logic                        out_valid_q;
  logic [SymW-1:0]             out_sym_q;
  logic [LenW-1:0]             out_rep_q;
  logic                        out_status_q;
  logic                        out_last_q;

  // stack of internal nodes whose right slot is still open
  logic [IdxW-1:0]             pend_mem [Depth];
  logic [IdxW-1:0]             pend_rd_q;
  logic                        pend_we;
  logic [IdxW-1:0]             pend_wdata;

  hsd_pkg::child_wr_t          child_wr;
  logic [NodeW-1:0]            left_rd, right_rd;

  logic                        emit;
  logic [SymW-1:0]             emit_sym;
  logic [LenW-1:0]             emit_rep;
  logic                        emit_status;
  logic                        emit_last;
  logic                        go;
  logic                        in_fire;
  logic                        cur_bit;
  logic [NodeW-1:0]            sp_dec;
  logic [NodeW:0]              new_node;
  logic [NodeW-1:0]            fill_val;
  logic                        fill_en;
  logic [NodeW-1:0]            root_eff;
  logic [NodeW-1:0]            child;
  logic [LenW-1:0]             prod_inc;
  logic [hsd_pkg::LeafCntW-1:0] cnt_dec;
  logic [SymW-1:0]             val_shift;
  logic                        tree_done;

  assign in_i.ready = (state_q == hsd_pkg::S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign cur_bit    = shift_q[SymW-1];
  assign sp_dec     = sp_q - NodeW'(1);
  assign new_node   = {1'b0, next_node_q} + IntBase;
  assign prod_inc   = produced_q + LenW'(1);
  assign cnt_dec    = leaf_cnt_q - hsd_pkg::LeafCntW'(1);
  assign val_shift  = {leaf_val_q[SymW-2:0], cur_bit};
  assign child      = cur_bit ? right_rd : left_rd;
  assign go         = !(emit && out_valid_q && !out_o.ready);

  hsd_child_mem u_child_mem (
    .clk_i     (clk_i),
    .wr_i      (child_wr),
    .rd_en_i   (state_q == hsd_pkg::S_FETCH),
    .rd_addr_i (walk_q[IdxW-1:0]),
    .left_o    (left_rd),
    .right_o   (right_rd)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    slot_d      = slot_q;
    shift_d     = shift_q;
    bit_cnt_d   = bit_cnt_q;
    sp_d        = sp_q;
    next_node_d = next_node_q;
    root_d      = root_q;
    walk_d      = walk_q;
    leaf_cnt_d  = leaf_cnt_q;
    leaf_val_d  = leaf_val_q;
    produced_d  = produced_q;
    slot_idx_d  = slot_idx_q;
    emit        = 1'b0;
    emit_sym    = '0;
    emit_rep    = LenW'(1);
    emit_status = hsd_pkg::ST_OK;
    emit_last   = 1'b1;
    pend_we     = 1'b0;
    pend_wdata  = new_node[IdxW-1:0];
    fill_en     = 1'b0;
    fill_val    = {1'b0, val_shift};
    tree_done   = 1'b0;
    root_eff    = root_q;

    unique case (state_q)
      hsd_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_i.start_req) begin
            phase_d     = hsd_pkg::PH_BUILD;
            slot_d      = hsd_pkg::SLOT_ROOT;
            sp_d        = '0;
            next_node_d = '0;
            root_d      = '0;
            walk_d      = '0;
            leaf_cnt_d  = '0;
            leaf_val_d  = '0;
            produced_d  = '0;
            slot_idx_d  = '0;
          end
          shift_d   = in_i.data_byte;
          bit_cnt_d = 3'd7;
          if (!in_i.start_req && phase_q == hsd_pkg::PH_STOP) begin
            state_d = hsd_pkg::S_IDLE;
          end else begin
            state_d = hsd_pkg::S_FETCH;
          end
        end
      end

      hsd_pkg::S_FETCH: begin
        state_d = hsd_pkg::S_EXEC;
      end

      hsd_pkg::S_EXEC: begin
        unique case (phase_q)
          hsd_pkg::PH_BUILD: begin
            if (leaf_cnt_q != '0) begin
              if (cnt_dec != '0) begin
                leaf_cnt_d = cnt_dec;
                leaf_val_d = val_shift;
              end else begin
                leaf_cnt_d = '0;
                leaf_val_d = '0;
                fill_en    = 1'b1;
                fill_val   = {1'b0, val_shift};
                if (sp_q == '0) begin
                  tree_done = 1'b1;
                  root_eff  = (slot_q == hsd_pkg::SLOT_ROOT) ? fill_val : root_q;
                end else begin
                  sp_d       = sp_dec;
                  slot_d     = hsd_pkg::SLOT_RIGHT;
                  slot_idx_d = pend_rd_q;
                end
              end
            end else if (!cur_bit) begin
              leaf_cnt_d = hsd_pkg::LeafBits;
            end else if (new_node >= MaxNode || next_node_q[NodeW-1]) begin
              emit        = 1'b1;
              emit_status = hsd_pkg::ST_OVERFLOW;
              phase_d     = hsd_pkg::PH_STOP;
            end else begin
              next_node_d = next_node_q + NodeW'(1);
              fill_en     = 1'b1;
              fill_val    = new_node[NodeW-1:0];
              pend_we     = 1'b1;
              sp_d        = sp_q + NodeW'(1);
              slot_d      = hsd_pkg::SLOT_LEFT;
              slot_idx_d  = new_node[IdxW-1:0];
            end
            if (fill_en && slot_q == hsd_pkg::SLOT_ROOT) begin
              root_d = fill_val;
            end
            if (tree_done) begin
              walk_d = root_eff;
              if (len_q == '0) begin
                phase_d = hsd_pkg::PH_STOP;
              end else if (!root_eff[NodeW-1]) begin
                emit       = 1'b1;
                emit_sym   = root_eff[SymW-1:0];
                emit_rep   = len_q;
                produced_d = len_q;
                phase_d    = hsd_pkg::PH_STOP;
              end else begin
                phase_d = hsd_pkg::PH_DECODE;
              end
            end
          end

          hsd_pkg::PH_DECODE: begin
            if (child[NodeW-1]) begin
              walk_d = child;
            end else begin
              produced_d = prod_inc;
              emit       = 1'b1;
              emit_sym   = child[SymW-1:0];
              emit_last  = (prod_inc >= len_q);
              walk_d     = root_q;
              if (prod_inc >= len_q) begin
                phase_d = hsd_pkg::PH_STOP;
              end
            end
          end

          default: begin
            phase_d = hsd_pkg::PH_STOP;
          end
        endcase

        shift_d = {shift_q[SymW-2:0], 1'b0};
        if (phase_d == hsd_pkg::PH_STOP || bit_cnt_q == '0) begin
          state_d = hsd_pkg::S_IDLE;
        end else begin
          state_d   = hsd_pkg::S_FETCH;
          bit_cnt_d = bit_cnt_q - 3'd1;
        end

        // hold everything while the pending result cannot be stored
        if (!go) begin
          state_d     = state_q;
          phase_d     = phase_q;
          slot_d      = slot_q;
          shift_d     = shift_q;
          bit_cnt_d   = bit_cnt_q;
          sp_d        = sp_q;
          next_node_d = next_node_q;
          root_d      = root_q;
          walk_d      = walk_q;
          leaf_cnt_d  = leaf_cnt_q;
          leaf_val_d  = leaf_val_q;
          produced_d  = produced_q;
          slot_idx_d  = slot_idx_q;
        end
      end

      default: begin
        state_d = hsd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    child_wr.we_left  = go && fill_en && (slot_q == hsd_pkg::SLOT_LEFT);
    child_wr.we_right = go && fill_en && (slot_q == hsd_pkg::SLOT_RIGHT);
    child_wr.addr     = slot_idx_q;
    child_wr.data     = fill_val;
  end

  always_ff @(posedge clk_i) begin
    if (go && pend_we) begin
      pend_mem[sp_q[IdxW-1:0]] <= pend_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == hsd_pkg::S_FETCH) begin
      pend_rd_q <= pend_mem[sp_dec[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsd_pkg::S_IDLE;
      phase_q     <= hsd_pkg::PH_BUILD;
      slot_q      <= hsd_pkg::SLOT_ROOT;
      shift_q     <= '0;
      bit_cnt_q   <= '0;
      sp_q        <= '0;
      next_node_q <= '0;
      root_q      <= '0;
      walk_q      <= '0;
      leaf_cnt_q  <= '0;
      leaf_val_q  <= '0;
      produced_q  <= '0;
      slot_idx_q  <= '0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      shift_q     <= shift_d;
      bit_cnt_q   <= bit_cnt_d;
      sp_q        <= sp_d;
      next_node_q <= next_node_d;
      root_q      <= root_d;
      walk_q      <= walk_d;
      leaf_cnt_q  <= leaf_cnt_d;
      leaf_val_q  <= leaf_val_d;
      produced_q  <= produced_d;
      slot_idx_q  <= slot_idx_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit && go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && go) begin
      out_sym_q    <= emit_sym;
      out_rep_q    <= emit_rep;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.symbol     = out_sym_q;
  assign out_o.repeat_res = out_rep_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire
